/* src/key_autorepeat_accelerating_top_assert.svh */
// assertion macros for the key autorepeat block
`ifndef KEY_AUTOREPEAT_ACCELERATING_TOP_ASSERT_SVH
`define KEY_AUTOREPEAT_ACCELERATING_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define KAR_ASSERT_IMPLY(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("key autorepeat assertion failed");

// next-cycle implication, disabled in reset
`define KAR_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("key autorepeat assertion failed");

`endif

/* src/kar_pkg.sv */
// shared types and constants for the key autorepeat block
package kar_pkg;

  localparam int KEY_BITS_DEF = 21;
  localparam int REG_W        = 8;
  localparam int PHASE_W      = 2;
  localparam int CFG_IDX_W    = 2;

  localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_REPEAT  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP_AFTER   = 2'd2;

  localparam logic [REG_W-1:0] INITIAL_DELAY_RST   = 8'd6;
  localparam logic [REG_W-1:0] REPEAT_INTERVAL_RST = 8'd4;
  localparam logic [REG_W-1:0] SPEEDUP_AFTER_RST   = 8'd4;

  typedef struct packed {
    logic [REG_W-1:0] initial_delay;
    logic [REG_W-1:0] repeat_interval;
    logic [REG_W-1:0] speedup_after;
  } cfg_t;

  // per-tick control from the phase logic to the datapath
  typedef struct packed {
    logic               blank;
    logic [PHASE_W-1:0] phase;
  } tick_res_t;

endpackage

/* src/kar_cfg.sv */
// configuration register file
module kar_cfg
  import kar_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay   <= INITIAL_DELAY_RST;
      cfg.repeat_interval <= REPEAT_INTERVAL_RST;
      cfg.speedup_after   <= SPEEDUP_AFTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_DELAY:   cfg.initial_delay   <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data;
        CFG_SPEEDUP_AFTER:   cfg.speedup_after   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* src/kar_fsm.sv */
// typematic phase machine with tick, interval and repeat counters
module kar_fsm
  import kar_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      any_key,
  input  logic      ir_busy,
  input  cfg_t      cfg,
  output tick_res_t res
);

  typedef enum logic [PHASE_W-1:0] {
    ST_IDLE    = PH_IDLE,
    ST_PRESSED = PH_PRESSED,
    ST_HOLD    = PH_HOLD,
    ST_REPEAT  = PH_REPEAT
  } state_t;

  state_t           state, state_next, state_entry;
  logic [REG_W-1:0] tick_count, tick_count_next, tick_base, tick_inc;
  logic [REG_W-1:0] cur_interval, cur_interval_next, interval_base;
  logic [REG_W-1:0] repeat_count, repeat_count_next, repeat_inc;
  logic             blank;

  always_comb begin
    if (!any_key) begin
      state_entry   = ST_IDLE;
      tick_base     = '0;
      interval_base = cfg.initial_delay;
    end else begin
      state_entry   = (state == ST_IDLE) ? ST_PRESSED : state;
      tick_base     = tick_count;
      interval_base = cur_interval;
    end
    tick_inc          = tick_base + 8'd1;
    repeat_inc        = repeat_count + 8'd1;
    state_next        = state_entry;
    tick_count_next   = tick_base;
    cur_interval_next = interval_base;
    repeat_count_next = repeat_count;
    blank             = 1'b0;
    unique case (state_entry)
      ST_IDLE: ;
      ST_PRESSED: begin
        tick_count_next = tick_inc;
        if (tick_inc > interval_base && interval_base != '0 && !ir_busy) begin
          cur_interval_next = cfg.repeat_interval;
          state_next        = ST_HOLD;
        end
      end
      ST_HOLD: begin
        blank      = 1'b1;
        state_next = ST_REPEAT;
      end
      ST_REPEAT: begin
        tick_count_next = tick_inc;
        if (tick_inc > interval_base) begin
          blank             = 1'b1;
          tick_count_next   = '0;
          repeat_count_next = repeat_inc;
          if (repeat_inc > cfg.speedup_after && interval_base > 8'd1) begin
            cur_interval_next = interval_base >> 1;
            repeat_count_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res.blank = blank;
  assign res.phase = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tick_count   <= '0;
      cur_interval <= '0;
      repeat_count <= '0;
    end else if (step) begin
      state        <= state_next;
      tick_count   <= tick_count_next;
      cur_interval <= cur_interval_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

/* src/key_autorepeat_accelerating_top.sv */
// key autorepeat filter: an accepted item's result reaches the outputs by this path
// (input register, then phase logic into the result register)
// one item per cycle while not stalled; in_stall follows out_stall when both registers are full
// the phase counters update when an item moves into the result register
// reset (synchronous) empties both registers, restores register defaults, phase idle
module key_autorepeat_accelerating_top
  import kar_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_BITS-1:0]  keys_first,
  input  logic [KEY_BITS-1:0]  keys_second,
  input  logic                 ir_busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_BITS-1:0]  out_keys_first,
  output logic [KEY_BITS-1:0]  out_keys_second,
  output logic [PHASE_W-1:0]   phase,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  cfg_t                cfg;
  tick_res_t           res;
  logic                s1_valid;
  logic [KEY_BITS-1:0] s1_keys_first, s1_keys_second;
  logic                s1_ir;
  logic                out_free;
  logic                step;
  logic                any_key;

  assign out_free = !out_valid || !out_stall;
  assign step     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign any_key  = (|s1_keys_first) || (|s1_keys_second);

  kar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kar_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .any_key (any_key),
    .ir_busy (s1_ir),
    .cfg     (cfg),
    .res     (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_keys_first  <= keys_first;
      s1_keys_second <= keys_second;
      s1_ir          <= ir_busy;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_keys_first  <= res.blank ? '0 : s1_keys_first;
      out_keys_second <= res.blank ? '0 : s1_keys_second;
      phase           <= res.phase;
    end
  end

endmodule

/* src/kar_checker.sv */
// port-level checks for the key autorepeat block, bound to the top level
`include "key_autorepeat_accelerating_top_assert.svh"

module kar_checker
  import kar_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [KEY_BITS-1:0] out_keys_first,
  input logic [KEY_BITS-1:0] out_keys_second,
  input logic [PHASE_W-1:0]  phase
);

  // idle is only reported for an item with every key released
  `KAR_ASSERT_IMPLY(a_idle_no_keys, clk, rst, out_valid && phase == PH_IDLE,
    out_keys_first == '0 && out_keys_second == '0)

  // entering hold passes the held keys through unblanked
  `KAR_ASSERT_IMPLY(a_hold_keys_seen, clk, rst, out_valid && phase == PH_HOLD,
    out_keys_first != '0 || out_keys_second != '0)

  // a pressed item always carries at least one key
  `KAR_ASSERT_IMPLY(a_pressed_keys_seen, clk, rst, out_valid && phase == PH_PRESSED,
    out_keys_first != '0 || out_keys_second != '0)

  // a stalled item holds
  `KAR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(out_keys_first) && $stable(out_keys_second) && $stable(phase))

endmodule

bind key_autorepeat_accelerating_top kar_checker #(.KEY_BITS(KEY_BITS)) u_kar_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_keys_first  (out_keys_first),
  .out_keys_second (out_keys_second),
  .phase           (phase)
);

/* tb/key_autorepeat_checker.sv */
// checker for the key autorepeat filter: predicts every result item and compares it
module key_autorepeat_checker
  import kar_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [KEY_BITS-1:0]  keys_first,
  input  logic [KEY_BITS-1:0]  keys_second,
  input  logic                 ir_busy,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [KEY_BITS-1:0]  out_keys_first,
  input  logic [KEY_BITS-1:0]  out_keys_second,
  input  logic [PHASE_W-1:0]   phase,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct {
    logic [KEY_BITS-1:0] keys_first;
    logic [KEY_BITS-1:0] keys_second;
    logic [PHASE_W-1:0]  phase;
  } tick_result_t;

  cfg_t               regs;
  logic [PHASE_W-1:0] phase_st;
  logic [REG_W-1:0]   tick_cnt;
  logic [REG_W-1:0]   cur_interval;
  logic [REG_W-1:0]   repeat_cnt;
  tick_result_t       expected_ticks[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic tick_result_t typematic_step(logic [KEY_BITS-1:0] k0,
                                                  logic [KEY_BITS-1:0] k1,
                                                  logic ir);
    tick_result_t r;
    logic         blank;
    blank = 1'b0;
    if (k0 == '0 && k1 == '0) begin
      tick_cnt     = '0;
      cur_interval = regs.initial_delay;
      phase_st     = PH_IDLE;
    end else if (phase_st == PH_IDLE) begin
      phase_st = PH_PRESSED;
    end
    case (phase_st)
      PH_PRESSED: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cur_interval && cur_interval != '0 && !ir) begin
          cur_interval = regs.repeat_interval;
          phase_st     = PH_HOLD;
        end
      end
      PH_HOLD: begin
        blank    = 1'b1;
        phase_st = PH_REPEAT;
      end
      PH_REPEAT: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt > cur_interval) begin
          blank      = 1'b1;
          tick_cnt   = '0;
          repeat_cnt = repeat_cnt + 8'd1;
          if (repeat_cnt > regs.speedup_after && cur_interval > 8'd1) begin
            cur_interval = cur_interval >> 1;
            repeat_cnt   = '0;
          end
        end
      end
      default: ;
    endcase
    r.keys_first  = blank ? '0 : k0;
    r.keys_second = blank ? '0 : k1;
    r.phase       = phase_st;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (rst) begin
      regs.initial_delay   = INITIAL_DELAY_RST;
      regs.repeat_interval = REPEAT_INTERVAL_RST;
      regs.speedup_after   = SPEEDUP_AFTER_RST;
      phase_st             = PH_IDLE;
      tick_cnt             = '0;
      cur_interval         = '0;
      repeat_cnt           = '0;
      expected_ticks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_DELAY:   regs.initial_delay   = cfg_data;
          CFG_REPEAT_INTERVAL: regs.repeat_interval = cfg_data;
          CFG_SPEEDUP_AFTER:   regs.speedup_after   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          $error("result item with nothing pending: keys %h %h phase %0d",
                 out_keys_first, out_keys_second, phase);
          fail_count++;
        end else begin
          want = expected_ticks.pop_front();
          if (out_keys_first !== want.keys_first) begin
            $error("out_keys_first: expected %h, actual %h", want.keys_first, out_keys_first);
            fail_count++;
          end
          if (out_keys_second !== want.keys_second) begin
            $error("out_keys_second: expected %h, actual %h", want.keys_second,
                   out_keys_second);
            fail_count++;
          end
          if (phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, phase);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_ticks.push_back(typematic_step(keys_first, keys_second, ir_busy));
    end
    pending = expected_ticks.size();
  end

endmodule

/* tb/tb.sv */
// testbench top for the key autorepeat filter: stimulus, stalls and verdict
module tb;
  import kar_pkg::*;

  localparam int                   KB         = KEY_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [KB-1:0]        keys_first;
  logic [KB-1:0]        keys_second;
  logic                 ir_busy;
  logic                 out_valid;
  logic                 out_stall;
  logic [KB-1:0]        out_keys_first;
  logic [KB-1:0]        out_keys_second;
  logic [PHASE_W-1:0]   phase;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending;
  int                   ticks_sent;
  bit                   calm_in;
  bit                   calm_out;

  key_autorepeat_accelerating_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .keys_first(keys_first), .keys_second(keys_second), .ir_busy(ir_busy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_keys_first(out_keys_first), .out_keys_second(out_keys_second), .phase(phase),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  key_autorepeat_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .keys_first(keys_first), .keys_second(keys_second), .ir_busy(ir_busy),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_keys_first(out_keys_first), .out_keys_second(out_keys_second), .phase(phase),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: per item a random stall, then ready until the item is taken
  initial begin
    int hold_off;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold_off = calm_out ? 0 : $urandom_range(0, 10);
      if (hold_off != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(logic [KB-1:0] k0, logic [KB-1:0] k1, logic ir);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    keys_first  <= k0;
    keys_second <= k1;
    ir_busy     <= ir;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    ticks_sent++;
  endtask

  task automatic hold_keys(logic [KB-1:0] k0, logic [KB-1:0] k1, logic ir, int n);
    repeat (n) send_tick(k0, k1, ir);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(logic [REG_W-1:0] delay, logic [REG_W-1:0] rate,
                          logic [REG_W-1:0] speedup);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [REG_W-1:0]     val [4];
    idx = '{CFG_UNUSED, CFG_INITIAL_DELAY, CFG_REPEAT_INTERVAL, CFG_SPEEDUP_AFTER};
    val = '{REG_W'($urandom), delay, rate, speedup};
    wait_drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_keys(output logic [KB-1:0] a, output logic [KB-1:0] b);
    case ($urandom_range(0, 3))
      0: begin a = KB'($urandom); b = KB'($urandom); end
      1: begin a = KB'(1) << $urandom_range(0, KB - 1); b = '0; end
      2: begin a = '0; b = KB'(1) << $urandom_range(0, KB - 1); end
      default: begin a = '1; b = '1; end
    endcase
    if (a == '0 && b == '0)
      a = KB'(1) << $urandom_range(0, KB - 1);
  endtask

  // well-formed press/hold/release bursts, with some noise and short presses
  task automatic run_phase(int n_ticks, int max_hold);
    int            stop_at;
    int            hold_len;
    logic [KB-1:0] a;
    logic [KB-1:0] b;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      calm_in  = ($urandom_range(0, 4) == 0);
      calm_out = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          a = ($urandom_range(0, 1) != 0) ? KB'($urandom) : '0;
          b = ($urandom_range(0, 1) != 0) ? KB'($urandom) : '0;
          send_tick(a, b, 1'($urandom));
        end
      end else begin
        hold_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                               : $urandom_range(1, max_hold);
        pick_keys(a, b);
        repeat (hold_len) begin
          if ($urandom_range(0, 15) == 0)
            pick_keys(a, b);
          send_tick(a, b, $urandom_range(0, 7) == 0);
        end
        repeat ($urandom_range(1, 3)) send_tick('0, '0, 1'($urandom));
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    keys_first  = '0;
    keys_second = '0;
    ir_busy     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_INITIAL_DELAY;
    cfg_data    = '0;
    ticks_sent  = 0;
    calm_in     = 1'b0;
    calm_out    = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero interval right after reset, then ir blocking, then hold and repeat
    hold_keys('1, '1, 1'b0, 3);
    hold_keys('0, '0, 1'b0, 1);
    hold_keys(KB'(1), '0, 1'b1, 8);
    hold_keys('0, KB'(1) << (KB - 1), 1'b0, 8);
    hold_keys('1, '0, 1'b1, 2);
    hold_keys('0, '0, 1'b1, 1);
    hold_keys('0, '1, 1'b0, 2);

    run_phase(60, 60);
    set_regs(8'd0, 8'd0, 8'd0);
    run_phase(70, 30);
    set_regs(8'd255, 8'd255, 8'd255);
    run_phase(60, 270);
    set_regs(8'd1, 8'd1, 8'd0);
    run_phase(70, 40);
    set_regs(8'd254, 8'd2, 8'd255);
    run_phase(60, 270);
    set_regs(REG_W'($urandom_range(0, 8)), REG_W'($urandom_range(0, 8)),
             REG_W'($urandom_range(0, 8)));
    run_phase(100, 60);
    set_regs(REG_W'($urandom), REG_W'($urandom_range(0, 20)),
             REG_W'($urandom_range(0, 10)));
    run_phase(60, 60);
    set_regs(REG_W'($urandom_range(1, 5)), REG_W'($urandom_range(2, 12)),
             REG_W'($urandom_range(0, 3)));
    run_phase(100, 80);

    wait_drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/kar_pkg.sv
src/kar_cfg.sv
src/kar_fsm.sv
src/key_autorepeat_accelerating_top.sv
src/kar_checker.sv
tb/key_autorepeat_checker.sv
tb/tb.sv
